### rtl/cba_pkg.sv
// Shared types and constants for the current budget allocator.
package cba_pkg;

  localparam int CurW  = 16;
  localparam int DutyW = 17;
  localparam int FreqW = 16;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_UPDATE  = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_NO_PIN   = 2'd2,
    ST_KIND_CHG = 2'd3
  } status_t;

  // Stored flags of one pin
  typedef struct packed {
    logic ovr;
    logic grant;
    logic des;
    logic pwm;
    logic crit;
  } flags_t;

  // One pin table entry
  typedef struct packed {
    logic [CurW-1:0]  cur;
    flags_t           flags;
    logic [DutyW-1:0] req;
    logic [DutyW-1:0] app;
    logic [FreqW-1:0] freq;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_P1_RD,
    S_P1_WB,
    S_P2_RD,
    S_P2_ACC,
    S_P3_RD,
    S_P3_WB,
    S_P3_DIV,
    S_P4_RD,
    S_P4_OUT
  } state_t;

endpackage

### rtl/current_budget_allocator.sv
// Top level of the current budget allocator: pin table, budget passes and result stream.
//
// Usage: write base_current_ma (index 0) and max_current_ma (index 1) on the cfg
// port while no command is in progress. Each transaction on the in_ channel is one
// command addressed to a pin; the out_ channel returns its results through a single
// output register, out_tlast on the final one. Commands above query are accepted
// and dropped without a result.
// Add, query, errors and enable/disable without change: after acceptance the LOOK
// and CHECK states read the entry; the result is loaded from CHECK as in_tready returns.
// Update, enable and disable re-evaluate in four passes over the pin table memory
// (critical grant, demand sum, duty scaling, report), each pin read in the pass's
// _RD state and handled in its _WB, _ACC or _OUT state; the duty scaling pass runs
// the 17-step divider in S_P3_DIV for every scaled PWM pin.
// One command is handled at a time; in_tready is high only while idle.
// A stalled receiver holds the output register; the check step and the report
// pass wait for it.
// Reset clears the valid bits, the registers and all control; entry contents are
// only read once their pin has been added, so the memory needs no clearing.
module current_budget_allocator #(
  parameter int NUM_PINS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: cmd[2:0], pin[6:3], load_current_ma[22:7], is_critical[23],
  // is_pwm[24], requested_duty[41:25], pwm_frequency[57:42], zero fill
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[1:0], out_pin[5:2], switch_on[6], duty[23:7],
  // out_frequency[39:24], desired[40], granted[41], overridden[42], zero fill
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import cba_pkg::*;

  localparam int IW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  // configuration
  logic [CurW-1:0] base_r, max_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      max_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index) max_r <= cfg_data;
      else base_r <= cfg_data;
    end
  end

  // input fields
  logic [2:0]       f_cmd;
  logic [3:0]       f_pin;
  logic [CurW-1:0]  f_cur;
  logic             f_crit, f_pwm;
  logic [DutyW-1:0] f_duty;
  logic [FreqW-1:0] f_freq;
  assign f_cmd  = in_tdata[2:0];
  assign f_pin  = in_tdata[6:3];
  assign f_cur  = in_tdata[22:7];
  assign f_crit = in_tdata[23];
  assign f_pwm  = in_tdata[24];
  assign f_duty = in_tdata[41:25];
  assign f_freq = in_tdata[57:42];

  // command registers
  cmd_t             cmd_r;
  logic [3:0]       pin_r;
  logic [CurW-1:0]  cur_r;
  logic             crit_r, pwm_r;
  logic [DutyW-1:0] duty_r;
  logic [FreqW-1:0] freq_r;

  // memory and valid bits
  entry_t              mem [NUM_PINS];
  logic [NUM_PINS-1:0] valid_r;
  entry_t              rd_q;
  logic [IW-1:0]       rd_addr;
  logic                mem_we;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_t           state_r, state_nxt;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    last_idx_r;
  logic [CurW-1:0]  budget_r;
  logic [63:0]      demand_r;
  // divider
  logic [63:0]      rem_r, dvs_r;
  logic [DutyW-1:0] quo_r;
  logic [4:0]       dcnt_r;
  // output register
  logic             ov_r;
  logic [47:0]      od_r;
  logic             ol_r;

  // walk control
  logic             adv;
  logic             set_valid;
  logic             o_load, o_last;
  logic [47:0]      o_data;

  logic [IW-1:0] pin_a;
  assign pin_a = IW'(pin_r);
  logic pin_ok;
  assign pin_ok = (32'(pin_r) < 32'(NUM_PINS));
  logic known;
  assign known = pin_ok && valid_r[pin_a];
  logic ofree;
  assign ofree = !ov_r || out_tready;
  logic idx_last;
  assign idx_last = (idx_r == IW'(NUM_PINS - 1));
  logic idx_valid;
  assign idx_valid = valid_r[idx_r];

  logic kind_bad, go_eval;
  assign kind_bad = (cmd_r == CMD_UPDATE) && (rd_q.flags.pwm != pwm_r);
  assign go_eval  = known && !kind_bad
                    && ((cmd_r == CMD_UPDATE)
                        || (cmd_r == CMD_ENABLE && !rd_q.flags.des)
                        || (cmd_r == CMD_DISABLE && rd_q.flags.des));

  logic is_ncpwm;
  assign is_ncpwm = rd_q.flags.pwm && !rd_q.flags.crit;
  logic is_crit_sw;
  assign is_crit_sw = idx_valid && rd_q.flags.crit && !rd_q.flags.pwm;
  logic crit_fits;
  assign crit_fits = (budget_r > rd_q.cur);
  logic [63:0] cap;
  assign cap = {32'd0, budget_r, 16'd0};
  logic [32:0] dem_prod;
  assign dem_prod = 33'(rd_q.cur) * 33'(rd_q.req);
  logic [32:0] num_prod;
  assign num_prod = 33'(rd_q.req) * 33'(budget_r);
  logic demand_zero, demand_fits;
  assign demand_zero = (demand_r <= 64'd65);
  assign demand_fits = (demand_r < cap);
  logic div_go;
  assign div_go = idx_valid && !demand_zero && is_ncpwm && !demand_fits;

  // pack a result word from an entry
  function automatic logic [47:0] pack(input status_t st, input logic [3:0] p,
                                       input logic show, input entry_t e);
    logic [47:0] w;
    w = '0;
    w[1:0] = st;
    w[5:2] = p;
    if (show) begin
      if (e.flags.pwm) begin
        w[23:7]  = e.app;
        w[39:24] = e.freq;
      end else begin
        w[6] = e.flags.grant;
      end
      w[40] = e.flags.des;
      w[41] = e.flags.grant;
      w[42] = e.flags.ovr;
    end
    return w;
  endfunction

  assign in_tready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid && f_cmd <= CMD_QUERY) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (go_eval) state_nxt = S_P1_RD;
        else if (ofree) state_nxt = S_IDLE;
      end
      S_P1_RD:  state_nxt = S_P1_WB;
      S_P1_WB:  state_nxt = idx_last ? S_P2_RD : S_P1_RD;
      S_P2_RD:  state_nxt = S_P2_ACC;
      S_P2_ACC: state_nxt = idx_last ? S_P3_RD : S_P2_RD;
      S_P3_RD:  state_nxt = S_P3_WB;
      S_P3_WB: begin
        if (div_go) state_nxt = S_P3_DIV;
        else state_nxt = idx_last ? S_P4_RD : S_P3_RD;
      end
      S_P3_DIV: if (dcnt_r == 5'd0) state_nxt = idx_last ? S_P4_RD : S_P3_RD;
      S_P4_RD:  state_nxt = S_P4_OUT;
      S_P4_OUT: if (!idx_valid || ofree) state_nxt = idx_last ? S_IDLE : S_P4_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory access, walk advance and result word
  always_comb begin
    rd_addr   = idx_r;
    mem_we    = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_q;
    adv       = 1'b0;
    set_valid = 1'b0;
    o_load    = 1'b0;
    o_last    = 1'b1;
    o_data    = '0;
    case (state_r)
      S_IDLE, S_LOOK: rd_addr = pin_a;
      S_CHECK: begin
        rd_addr = pin_a;
        wr_addr = pin_a;
        if (go_eval) begin
          // apply the command to its entry before the passes
          mem_we = 1'b1;
          if (cmd_r == CMD_UPDATE) begin
            wr_data.cur        = cur_r;
            wr_data.flags.crit = crit_r;
            wr_data.req        = duty_r;
            wr_data.freq       = freq_r;
          end else begin
            wr_data.flags.des = (cmd_r == CMD_ENABLE);
          end
        end else if (ofree) begin
          o_load = 1'b1;
          if (!pin_ok) begin
            o_data = pack(ST_NO_PIN, pin_r, 1'b0, rd_q);
          end else if (cmd_r == CMD_ADD) begin
            if (known) begin
              o_data = pack(ST_EXISTS, pin_r, 1'b0, rd_q);
            end else begin
              // store the new pin, switched off with its requested duty
              mem_we             = 1'b1;
              set_valid          = 1'b1;
              wr_data            = '0;
              wr_data.cur        = cur_r;
              wr_data.flags.crit = crit_r;
              wr_data.flags.pwm  = pwm_r;
              wr_data.req        = duty_r;
              wr_data.app        = duty_r;
              wr_data.freq       = freq_r;
              o_data = pack(ST_OK, pin_r, 1'b0, rd_q);
              if (pwm_r) o_data[39:24] = freq_r;
            end
          end else if (!known) begin
            o_data = pack(ST_NO_PIN, pin_r, 1'b0, rd_q);
          end else if (kind_bad) begin
            o_data = pack(ST_KIND_CHG, pin_r, 1'b0, rd_q);
          end else begin
            o_data = pack(ST_OK, pin_r, 1'b1, rd_q);
          end
        end
      end
      S_P1_WB: begin
        // grant each desired critical switch that leaves the remainder positive, mark the others overridden
        adv = 1'b1;
        if (is_crit_sw) begin
          mem_we = 1'b1;
          wr_data.flags.grant = rd_q.flags.des && crit_fits;
          wr_data.flags.ovr   = rd_q.flags.des && !crit_fits;
        end
      end
      S_P2_ACC: adv = 1'b1;
      S_P3_WB: begin
        if (!div_go) adv = 1'b1;
        if (idx_valid && demand_zero) begin
          mem_we = 1'b1;
          wr_data.app = '0;
        end else if (idx_valid && is_ncpwm && demand_fits) begin
          mem_we = 1'b1;
          wr_data.app = rd_q.req;
        end
      end
      S_P3_DIV: begin
        if (dcnt_r == 5'd0) begin
          adv = 1'b1;
          mem_we = 1'b1;
          wr_data.app = quo_r;
        end
      end
      S_P4_OUT: begin
        if (!idx_valid) begin
          adv = 1'b1;
        end else if (ofree) begin
          adv    = 1'b1;
          o_load = 1'b1;
          o_last = (idx_r == last_idx_r);
          o_data = pack(ST_OK, 4'(idx_r), 1'b1, rd_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      idx_r      <= '0;
      last_idx_r <= '0;
      budget_r   <= '0;
      demand_r   <= '0;
      rem_r      <= '0;
      dvs_r      <= '0;
      quo_r      <= '0;
      dcnt_r     <= '0;
      ov_r       <= 1'b0;
      od_r       <= '0;
      ol_r       <= 1'b0;
      cmd_r      <= CMD_ADD;
      pin_r      <= '0;
      cur_r      <= '0;
      crit_r     <= 1'b0;
      pwm_r      <= 1'b0;
      duty_r     <= '0;
      freq_r     <= '0;
    end else begin
      state_r <= state_nxt;
      // latch the accepted command
      if (in_tvalid && in_tready) begin
        cmd_r <= cmd_t'(f_cmd); pin_r <= f_pin; cur_r <= f_cur; crit_r <= f_crit;
        pwm_r <= f_pwm; duty_r <= f_duty; freq_r <= f_freq;
      end
      if (set_valid) valid_r[pin_a] <= 1'b1;
      // walk index and pass accumulators
      if (state_r == S_CHECK && go_eval) begin
        idx_r    <= '0;
        demand_r <= '0;
        budget_r <= (max_r > base_r) ? max_r - base_r : '0;
      end else if (adv) begin
        idx_r <= idx_last ? '0 : idx_r + IW'(1);
      end
      if (state_r == S_P1_WB) begin
        if (idx_valid) last_idx_r <= idx_r;
        if (is_crit_sw && rd_q.flags.des && crit_fits) budget_r <= budget_r - rd_q.cur;
      end
      if (state_r == S_P2_ACC && idx_valid && is_ncpwm) demand_r <= demand_r + 64'(dem_prod);
      // scale the duty: 17 restoring steps, quotient never above the request
      if (state_r == S_P3_WB && div_go) begin
        rem_r  <= {15'd0, num_prod, 16'd0};
        dvs_r  <= {demand_r[47:0], 16'd0};
        quo_r  <= '0;
        dcnt_r <= 5'd17;
      end else if (state_r == S_P3_DIV && dcnt_r != 5'd0) begin
        if (rem_r >= dvs_r) begin
          rem_r <= rem_r - dvs_r;
          quo_r <= {quo_r[DutyW-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[DutyW-2:0], 1'b0};
        end
        dvs_r  <= {1'b0, dvs_r[63:1]};
        dcnt_r <= dcnt_r - 5'd1;
      end
      // output register: load when free, drop after the transaction
      if (o_load) begin
        ov_r <= 1'b1;
        od_r <= o_data;
        ol_r <= o_last;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("result changed while stalled");
`endif
endmodule
